>>> design/msfd_pkg.sv
// ----------------------------------------------------------------------------
// Mode S frame deinterleaver package
// Shared constants, state encoding and the control and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package msfd_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned SyncWidth  = 20;
  localparam int unsigned MaxWords   = 8;
  localparam int unsigned CountWidth = $clog2(MaxWords + 1);
  localparam int unsigned AddrWidth  = $clog2(MaxWords);
  localparam int unsigned ShortWords = 5;
  localparam int unsigned LongWords  = 8;
  localparam int unsigned ShortBytes = 56 / 8;
  localparam int unsigned LongBytes  = 112 / 8;

  localparam logic [SyncWidth-1:0] SyncReset = 20'hAD50B;

  typedef enum logic [0:0] {
    StIdle,
    StEmit
  } state_e;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic header;
    logic frame_ok;
    logic last_byte;
    logic out_free;
  } status_t;

endpackage

>>> design/msfd_ctrl.sv
// ----------------------------------------------------------------------------
// Mode S frame deinterleaver controller
// Gates input transfers and sequences the byte output of a closed frame.
// ----------------------------------------------------------------------------
module msfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  msfd_pkg::status_t status_i,
  output msfd_pkg::cmd_t    cmd_o
);

  msfd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msfd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msfd_pkg::StIdle: begin
        if (in_valid_i && status_i.header && status_i.frame_ok) begin
          state_d = msfd_pkg::StEmit;
        end
      end
      msfd_pkg::StEmit: begin
        if (status_i.out_free && status_i.last_byte) begin
          state_d = msfd_pkg::StIdle;
        end
      end
      default: state_d = msfd_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_stall_o   = 1'b1;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    unique case (state_q)
      msfd_pkg::StIdle: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      msfd_pkg::StEmit: begin
        cmd_o.load = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> design/msfd_datapath.sv
// ----------------------------------------------------------------------------
// Mode S frame deinterleaver datapath
// Holds the sync register, the word store and count, the byte counter and the
// output register, and unpacks data and confidence bit pairs into bytes.
// ----------------------------------------------------------------------------
module msfd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [msfd_pkg::SyncWidth-1:0]    cfg_data_i,
  input  logic [msfd_pkg::WordWidth-1:0]    fifo_word_i,
  input  msfd_pkg::cmd_t                     cmd_i,
  output msfd_pkg::status_t                  status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        data_byte_o,
  output logic [7:0]                        confidence_byte_o,
  output logic [3:0]                        byte_index_o,
  output logic                              long_frame_o,
  output logic                              last_o
);

  logic [msfd_pkg::SyncWidth-1:0]  sync_q;
  logic [msfd_pkg::WordWidth-1:0]  store_q [msfd_pkg::MaxWords];
  logic [msfd_pkg::CountWidth-1:0] count_q;
  logic [3:0]                      byte_q;
  logic                            long_q;
  logic                            out_valid_q;
  logic [7:0]                      data_q;
  logic [7:0]                      conf_q;
  logic [3:0]                      index_q;
  logic                            long_out_q;
  logic                            last_q;

  logic [msfd_pkg::AddrWidth-1:0]  rd_addr;
  logic [msfd_pkg::WordWidth-1:0]  rd_word;
  logic [15:0]                     half;
  logic [7:0]                      data_d;
  logic [7:0]                      conf_d;
  logic                            header;
  logic                            room;

  assign header = (fifo_word_i[31:12] == sync_q);
  assign room   = (count_q < msfd_pkg::CountWidth'(msfd_pkg::MaxWords));

  assign rd_addr = msfd_pkg::AddrWidth'(byte_q[3:1]) + msfd_pkg::AddrWidth'(1);
  assign rd_word = store_q[rd_addr];
  assign half    = byte_q[0] ? rd_word[15:0] : rd_word[31:16];

  always_comb begin
    for (int t = 0; t < 8; t++) begin
      data_d[7-t] = half[15-2*t];
      conf_d[7-t] = half[14-2*t];
    end
  end

  assign status_o.header    = header;
  assign status_o.frame_ok  = (count_q == msfd_pkg::CountWidth'(msfd_pkg::ShortWords)) ||
                              (count_q == msfd_pkg::CountWidth'(msfd_pkg::LongWords));
  assign status_o.last_byte = long_q ? (byte_q == 4'(msfd_pkg::LongBytes - 1))
                                     : (byte_q == 4'(msfd_pkg::ShortBytes - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= msfd_pkg::SyncReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        sync_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        if (header) begin
          count_q <= msfd_pkg::CountWidth'(1);
        end else if (room) begin
          count_q <= count_q + msfd_pkg::CountWidth'(1);
        end
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (header) begin
        store_q[0] <= fifo_word_i;
        long_q     <= (count_q == msfd_pkg::CountWidth'(msfd_pkg::LongWords));
        byte_q     <= '0;
      end else if (room) begin
        store_q[count_q[msfd_pkg::AddrWidth-1:0]] <= fifo_word_i;
      end
    end
    if (cmd_i.load) begin
      data_q     <= data_d;
      conf_q     <= conf_d;
      index_q    <= byte_q;
      long_out_q <= long_q;
      last_q     <= status_o.last_byte;
      byte_q     <= byte_q + 4'd1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign data_byte_o       = data_q;
  assign confidence_byte_o = conf_q;
  assign byte_index_o      = index_q;
  assign long_frame_o      = long_out_q;
  assign last_o            = last_q;

endmodule

>>> design/mode_s_frame_deinterleaver.sv
// ----------------------------------------------------------------------------
// Mode S frame deinterleaver
// Collects receiver FIFO words into frames and emits packed message bytes.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid_i/in_stall_o with fifo_word_i. A word whose
// top 20 bits match the sync register closes the frame held so far and is
// stored as the first word of a new one. A closed frame of five words gives
// seven byte transfers and one of eight words gives fourteen, on out_valid_o
// and out_stall_i, each carrying a data byte, a confidence byte, its index,
// the long-frame flag and a last flag. A longer frame keeps its first eight
// words and gives fourteen; other lengths give nothing. A word that causes no
// output is taken without a stall. A header that closes a valid frame holds
// the input stalled while the frame's bytes are loaded into the output
// register, one per cycle while the receiver does not stall. The first
// byte is loaded once the controller has entered its emit state, and the
// input reopens in the cycle after the last byte is loaded.
// While the receiver stalls, the output register holds its byte and loading
// pauses. Reset clears the word count, the output valid and restores the sync
// register; the sync register is written through cfg_valid_i, always ready.
// ----------------------------------------------------------------------------
module mode_s_frame_deinterleaver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [msfd_pkg::SyncWidth-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [msfd_pkg::WordWidth-1:0] fifo_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     data_byte_o,
  output logic [7:0]                     confidence_byte_o,
  output logic [3:0]                     byte_index_o,
  output logic                           long_frame_o,
  output logic                           last_o
);

  msfd_pkg::cmd_t    cmd;
  msfd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  msfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msfd_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .fifo_word_i       (fifo_word_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .data_byte_o       (data_byte_o),
    .confidence_byte_o (confidence_byte_o),
    .byte_index_o      (byte_index_o),
    .long_frame_o      (long_frame_o),
    .last_o            (last_o)
  );

endmodule

>>> design/msfd_checker.sv
// ----------------------------------------------------------------------------
// Mode S frame deinterleaver checker
// Port-level checks on output sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module msfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] byte_index_o,
  input logic       long_frame_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output valid dropped while stalled.");

  a_next_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && (byte_index_o == $past(byte_index_o) + 4'd1))
    else $error("Message bytes not transferred in sequence.");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |->
      (long_frame_o && byte_index_o == 4'd13) || (!long_frame_o && byte_index_o == 4'd6))
    else $error("Last byte at the wrong index.");

  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("Input open while a message is still being emitted.");

endmodule

bind mode_s_frame_deinterleaver msfd_checker u_msfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .byte_index_o (byte_index_o),
  .long_frame_o (long_frame_o),
  .last_o       (last_o)
);

>>> sim/tb_mode_s_frame_deinterleaver.sv
// ----------------------------------------------------------------------------
// Testbench for the Mode S frame deinterleaver
// A directed table of FIFO words is followed by phases of random frames, each
// under its own sync register setting and idling mix. Every byte transfer is
// checked, field by field, against table fill bytes or a frame store model.
// ----------------------------------------------------------------------------
module tb_mode_s_frame_deinterleaver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 20;
  localparam int WordsPerPhase = 23;
  localparam int Untyped = -1;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] conf;
    logic [3:0] idx;
    logic       long_frame;
    logic       last_flag;
  } msg_byte_t;

  typedef struct {
    logic [msfd_pkg::WordWidth-1:0] word;
    int                             typed_n;
    logic [7:0]                     data_fill;
    logic [7:0]                     conf_fill;
  } word_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [msfd_pkg::SyncWidth-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [msfd_pkg::WordWidth-1:0] fifo_word_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [7:0]                     data_byte_o;
  logic [7:0]                     confidence_byte_o;
  logic [3:0]                     byte_index_o;
  logic                           long_frame_o;
  logic                           last_o;

  mode_s_frame_deinterleaver u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .fifo_word_i      (fifo_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .confidence_byte_o(confidence_byte_o),
    .byte_index_o     (byte_index_o),
    .long_frame_o     (long_frame_o),
    .last_o           (last_o)
  );

  // Model of the frame store and the sync register.
  logic [msfd_pkg::WordWidth-1:0] frame_words [msfd_pkg::MaxWords];
  int unsigned                    frame_len = 0;
  logic [msfd_pkg::SyncWidth-1:0] sync_word = msfd_pkg::SyncReset;
  msg_byte_t                      msg_bytes [msfd_pkg::LongBytes];

  msg_byte_t  pending_bytes [$];
  word_row_t  word_table [$];
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  int         error_count = 0;
  int         words_sent = 0;
  int         bytes_checked = 0;
  int         short_msgs = 0;
  int         long_msgs = 0;
  int         cycle_count = 0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $realtime, CycleLimit);
      $display("tb_mode_s_frame_deinterleaver: errors");
      $finish;
    end
  end

  // Returns the number of message bytes that a frame of frame_len words gives.
  function automatic int unpack_frame();
    int n_bytes;
    int bit_no;
    int pos;
    logic [msfd_pkg::WordWidth-1:0] w;
    if (frame_len == msfd_pkg::ShortWords) n_bytes = msfd_pkg::ShortBytes;
    else if (frame_len == msfd_pkg::LongWords) n_bytes = msfd_pkg::LongBytes;
    else return 0;
    for (int b = 0; b < n_bytes; b++) begin
      for (int t = 0; t < 8; t++) begin
        bit_no = b * 8 + t;
        w = frame_words[((bit_no >> 4) + 1) % msfd_pkg::MaxWords];
        pos = 30 - 2 * (bit_no & 15);
        msg_bytes[b].data[7-t] = w[pos+1];
        msg_bytes[b].conf[7-t] = w[pos];
      end
      msg_bytes[b].idx = 4'(b);
      msg_bytes[b].long_frame = (n_bytes == msfd_pkg::LongBytes);
      msg_bytes[b].last_flag = (b == n_bytes - 1);
    end
    return n_bytes;
  endfunction

  function automatic int absorb_word(logic [msfd_pkg::WordWidth-1:0] w);
    int n_bytes;
    n_bytes = 0;
    if (w[msfd_pkg::WordWidth-1 -: msfd_pkg::SyncWidth] == sync_word) begin
      n_bytes = unpack_frame();
      frame_len = 0;
    end
    if (frame_len < msfd_pkg::MaxWords) begin
      frame_words[frame_len] = w;
      frame_len++;
    end
    return n_bytes;
  endfunction

  task automatic send_word(logic [msfd_pkg::WordWidth-1:0] w, int typed_n = Untyped,
                           logic [7:0] data_fill = 8'h00, logic [7:0] conf_fill = 8'h00);
    int n_bytes;
    msg_byte_t mb;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    fifo_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    n_bytes = absorb_word(w);
    if (n_bytes == msfd_pkg::ShortBytes) short_msgs++;
    if (n_bytes == msfd_pkg::LongBytes) long_msgs++;
    if (typed_n == Untyped) begin
      for (int b = 0; b < n_bytes; b++) pending_bytes.push_back(msg_bytes[b]);
    end else begin
      for (int b = 0; b < typed_n; b++) begin
        mb.data = data_fill;
        mb.conf = conf_fill;
        mb.idx = 4'(b);
        mb.long_frame = (typed_n == msfd_pkg::LongBytes);
        mb.last_flag = (b == typed_n - 1);
        pending_bytes.push_back(mb);
      end
    end
  endtask

  function automatic logic [msfd_pkg::WordWidth-1:0] payload_word();
    logic [msfd_pkg::WordWidth-1:0] w;
    do w = $urandom; while (w[msfd_pkg::WordWidth-1 -: msfd_pkg::SyncWidth] == sync_word);
    return w;
  endfunction

  task automatic send_frame();
    int n_words;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) n_words = msfd_pkg::ShortWords;
    else if (pick < 80) n_words = msfd_pkg::LongWords;
    else n_words = $urandom_range(11, 1);
    send_word({sync_word, 12'($urandom)});
    for (int i = 1; i < n_words; i++) send_word(payload_word());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_sync(logic [msfd_pkg::SyncWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sync_word = value;
  endtask

  task automatic compare_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $realtime, fname, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : byte_monitor
    msg_byte_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte transfer, expected none, got data %0h conf %0h index %0d",
                 $realtime, data_byte_o, confidence_byte_o, byte_index_o);
        error_count++;
      end else begin
        want = pending_bytes.pop_front();
        compare_field("data_byte", want.data, data_byte_o);
        compare_field("confidence_byte", want.conf, confidence_byte_o);
        compare_field("byte_index", want.idx, byte_index_o);
        compare_field("long_frame", want.long_frame, long_frame_o);
        compare_field("last", want.last_flag, last_o);
        bytes_checked++;
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic add_row(logic [msfd_pkg::WordWidth-1:0] w, int typed_n = Untyped,
                         logic [7:0] data_fill = 8'h00, logic [7:0] conf_fill = 8'h00);
    word_row_t r;
    r.word = w;
    r.typed_n = typed_n;
    r.data_fill = data_fill;
    r.conf_fill = conf_fill;
    word_table.push_back(r);
  endtask

  initial begin
    logic [msfd_pkg::SyncWidth-1:0] phase_sync [4];
    int phase_sender [4];
    int phase_receiver [4];
    int phase_start;

    // Five words ahead of the first header form a short frame of their own.
    add_row(32'h0000_0000);
    add_row(32'hFFFF_FFFF);
    add_row(32'h5555_5555);
    add_row(32'hAAAA_AAAA);
    add_row(32'h1234_5678);
    add_row({msfd_pkg::SyncReset, 12'h5A5});
    repeat (4) add_row(32'hFFFF_FFFF);
    add_row({msfd_pkg::SyncReset, 12'h000}, msfd_pkg::ShortBytes, 8'hFF, 8'hFF);
    // An overlong frame keeps only its first eight words.
    repeat (7) add_row(32'hAAAA_AAAA);
    repeat (2) add_row(32'h5555_5555);
    add_row({msfd_pkg::SyncReset, 12'hFFF}, msfd_pkg::LongBytes, 8'hFF, 8'h00);
    // Frames of two words and of one word are discarded.
    add_row(32'h5555_5555);
    add_row({msfd_pkg::SyncReset, 12'h0F0}, 0);
    add_row({msfd_pkg::SyncReset, 12'hF0F}, 0);

    phase_sync = '{20'h00000, 20'hFFFFF, 20'($urandom), msfd_pkg::SyncReset};
    phase_sender = '{83, 0, 31, 0};
    phase_receiver = '{0, 83, 31, 0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (word_table[i])
      send_word(word_table[i].word, word_table[i].typed_n, word_table[i].data_fill,
                word_table[i].conf_fill);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_sync(phase_sync[p]);
      sender_idle_pct = phase_sender[p];
      receiver_stall_pct = phase_receiver[p];
      phase_start = words_sent;
      while (words_sent - phase_start < WordsPerPhase) begin
        if ($urandom_range(99) < 15) send_word($urandom);
        else send_frame();
      end
      send_word({sync_word, 12'($urandom)});
      drain();
    end

    $display("Covered %0d FIFO words and %0d byte transfers: %0d short and %0d long messages,",
             words_sent, bytes_checked, short_msgs, long_msgs);
    $display("under four sync settings including both extremes and four idling mixes.");
    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("tb_mode_s_frame_deinterleaver: clean");
    end else begin
      $display("tb_mode_s_frame_deinterleaver: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
design/msfd_pkg.sv
design/msfd_ctrl.sv
design/msfd_datapath.sv
design/mode_s_frame_deinterleaver.sv
design/msfd_checker.sv
sim/tb_mode_s_frame_deinterleaver.sv
